>>> rtl/projectile_intercept_aim_defines.svh
// assertion macros for the projectile intercept aim block
`ifndef PROJECTILE_INTERCEPT_AIM_DEFINES_SVH
`define PROJECTILE_INTERCEPT_AIM_DEFINES_SVH
`ifndef SYNTH
`define PIA_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define PIA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define PIA_ASSERT_IMPL(lbl, pre, post, msg)
`define PIA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> rtl/pia_pkg.sv
// shared constants and pipeline sideband types for the intercept aim block
package pia_pkg;

	localparam int IN_W = 24;
	localparam int SPD_W = 23;
	localparam int AIM_W = 16;
	localparam int TIME_W = 24;
	localparam logic [SPD_W-1:0] SPEED_MIN = 23'd256;
	localparam int LIN_A_MAX = 65;
	localparam int LIN_H_MIN = 33;
	localparam logic [TIME_W-1:0] TIME_SAT = 24'hFFFFFF;
	localparam int Q14_SHIFT = 14;
	localparam int NORM_MSB = 29;

	typedef struct packed {
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [23:0] vx;
		logic signed [23:0] vy;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic slow;
		logic lin;
		logic linok;
		logic apos;
		logic signed [50:0] g;
		logic [49:0] am;
		logic [49:0] hm;
		logic [49:0] c;
	} sol_t;

	typedef struct packed {
		sol_t sol;
		logic disc_ok;
	} sq1_sb_t;

	typedef struct packed {
		logic found;
		logic sat;
		geo_t geo;
	} dv1_sb_t;

	typedef struct packed {
		logic [29:0] nx;
		logic [29:0] ny;
		logic sx;
		logic sy;
		logic zero;
		logic [TIME_W-1:0] tq;
		logic found;
	} sq2_sb_t;

	typedef struct packed {
		logic sx;
		logic zero;
		logic [TIME_W-1:0] tq;
		logic found;
	} dv2_sb_t;

endpackage

>>> rtl/pia_isqrt.sv
// pipelined floor square root, one root bit per stage
module pia_isqrt #(
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [QW-1:0]       rad,
	input  logic [SW-1:0]       in_sb,
	output logic                out_valid,
	output logic [QW/2-1:0]     root,
	output logic [SW-1:0]       out_sb
);
	localparam int RW = QW / 2;

	logic [QW-1:0] rem_s [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [SW-1:0] sb_s [RW+1];
	logic          v_s [RW+1];

	assign rem_s[0] = rad;
	assign root_s[0] = '0;
	assign sb_s[0] = in_sb;
	assign v_s[0] = in_valid;

	for (genvar k = 1; k <= RW; k++) begin : g_stage
		localparam int B = RW - k;
		logic [QW:0] trial;
		assign trial = ((QW+1)'(root_s[k-1]) << (B + 1)) | ((QW+1)'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_s[k-1];
				if ({1'b0, rem_s[k-1]} >= trial) begin
					rem_s[k] <= rem_s[k-1] - QW'(trial);
					root_s[k] <= root_s[k-1] | (RW'(1) << B);
				end else begin
					rem_s[k] <= rem_s[k-1];
					root_s[k] <= root_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root = root_s[RW];
	assign out_sb = sb_s[RW];
endmodule

>>> rtl/pia_div.sv
// pipelined restoring divider, one quotient bit per stage
module pia_div #(
	parameter int NW = 8,
	parameter int DW = 8,
	parameter int QW = 8,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_sb,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] out_sb
);
	localparam int WW = (NW > DW + QW) ? NW : DW + QW;

	logic [WW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [SW-1:0] sb_s [QW+1];
	logic          v_s [QW+1];

	assign rem_s[0] = WW'(num);
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign sb_s[0] = in_sb;
	assign v_s[0] = in_valid;

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		localparam int B = QW - k;
		logic [WW-1:0] trial;
		assign trial = WW'(den_s[k-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= sb_s[k-1];
				den_s[k] <= den_s[k-1];
				if (rem_s[k-1] >= trial) begin
					rem_s[k] <= rem_s[k-1] - trial;
					quo_s[k] <= quo_s[k-1] | (QW'(1) << B);
				end else begin
					rem_s[k] <= rem_s[k-1];
					quo_s[k] <= quo_s[k-1];
				end
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo = quo_s[QW];
	assign out_sb = sb_s[QW];
endmodule

>>> rtl/projectile_intercept_aim.sv
// top level of the projectile lead intercept aim pipeline
//
//  channel  signals                                   direction
//  in       in_valid, in_ready, origin_*, target_*,   into block
//           target_vel_*, shot_speed
//  out      out_valid, out_ready, aim_x, aim_y,       out of block
//           hit_time, lead_used
//
// one beat per cycle enters while no finished beat waits at the output; the
// pipeline runs through the 49 stage discriminant square root, the 24 stage time
// divider, the 31 stage length square root and the 15 stage aim dividers.
// reset clears only the valid bits; the pipeline holds still while a
// finished beat waits at the output and fills bubbles otherwise.
`include "projectile_intercept_aim_defines.svh"

module projectile_intercept_aim
	import pia_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_W-1:0]   origin_x,
	input  logic signed [IN_W-1:0]   origin_y,
	input  logic signed [IN_W-1:0]   target_x,
	input  logic signed [IN_W-1:0]   target_y,
	input  logic signed [IN_W-1:0]   target_vel_x,
	input  logic signed [IN_W-1:0]   target_vel_y,
	input  logic [SPD_W-1:0]         shot_speed,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [AIM_W-1:0]  aim_x,
	output logic signed [AIM_W-1:0]  aim_y,
	output logic [TIME_W-1:0]        hit_time,
	output logic                     lead_used
);
	localparam int GRP = 7;
	localparam int NGRP = 7;

	logic en;
	assign en = out_ready | ~out_valid;
	assign in_ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19;

	// s1: differences
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [23:0] vx_s1, vy_s1;
	logic [SPD_W-1:0]   sp_s1;
	// s2: products
	logic [47:0]        pvx_s2, pvy_s2;
	logic [45:0]        pss_s2;
	logic [49:0]        pdx_s2, pdy_s2;
	logic signed [48:0] phx_s2, phy_s2;
	logic               slow_s2;
	geo_t               geo_s2;
	// s3: quadratic coefficients
	logic signed [49:0] a_s3;
	logic signed [50:0] h_s3;
	logic [49:0]        c_s3;
	logic               slow_s3;
	geo_t               geo_s3;
	// s4..s7: discriminant
	sol_t               sol_s4, sol_s5, sol_s6;
	logic [49:0]        hh00_s5, hh01_s5, hh11_s5;
	logic [49:0]        ac00_s5, ac01_s5, ac10_s5, ac11_s5;
	logic [99:0]        hh_s6, ac_s6;
	logic [97:0]        q_s7;
	sq1_sb_t            sq1_s7;
	// first square root
	logic               v_r1;
	logic [48:0]        r1;
	sq1_sb_t            sq1o;
	// s8, s9: root choice and divider setup
	logic signed [51:0] gm_c, gp_c;
	logic               found_c;
	logic [50:0]        num_c, den_c;
	logic [50:0]        num_s8, den_s8;
	logic               found_s8;
	geo_t               geo_s8;
	logic [66:0]        nn_s9;
	logic [50:0]        den_s9;
	dv1_sb_t            dv1_s9;
	// time divider
	logic               v_d1;
	logic [TIME_W-1:0]  q1;
	dv1_sb_t            dv1o;
	// s10..s16: lead vector and normalizing
	logic [TIME_W-1:0]  tq_s10, tq_s11, tq_s12, tq_s13, tq_s14, tq_s15, tq_s16;
	logic               found_s10, found_s11, found_s12, found_s13, found_s14;
	logic               found_s15, found_s16;
	geo_t               geo_s10;
	logic signed [48:0] pvx_s11, pvy_s11;
	logic signed [24:0] dx_s11, dy_s11;
	logic signed [49:0] x_s12, y_s12;
	logic [48:0]        mx_s13, my_s13, mx_s14, my_s14, mx_s15, my_s15;
	logic               sx_s13, sy_s13, sx_s14, sy_s14, sx_s15, sy_s15, sx_s16, sy_s16;
	logic [48:0]        mo_c;
	logic [NGRP-1:0]    gnz_c, gnz_s14;
	logic [NGRP-1:0][2:0] gpos_c, gpos_s14;
	logic [5:0]         p_c, p_s15;
	logic               zero_s15, zero_s16;
	logic [5:0]         sh_c;
	logic [29:0]        nx_c, ny_c, nx_s16, ny_s16;
	// s17, s18: squared length
	logic [59:0]        sqx_s17, sqy_s17;
	sq2_sb_t            sq2_s17;
	logic [61:0]        ss_s18;
	sq2_sb_t            sq2_s18;
	// second square root
	logic               v_r2;
	logic [30:0]        r2;
	sq2_sb_t            sq2o;
	// s19: aim dividers
	logic [44:0]        ndx_s19, ndy_s19;
	logic [30:0]        len_s19;
	dv2_sb_t            dv2_s19;
	logic               sy_s19;
	logic               dax_v, day_v;
	logic [14:0]        qx, qy;
	dv2_sb_t            dv2o;
	logic               syo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6;
			v_s8 <= v_r1; v_s9 <= v_s8;
			v_s10 <= v_d1; v_s11 <= v_s10; v_s12 <= v_s11; v_s13 <= v_s12;
			v_s14 <= v_s13; v_s15 <= v_s14; v_s16 <= v_s15; v_s17 <= v_s16;
			v_s18 <= v_s17;
			v_s19 <= v_r2;
			out_valid <= dax_v;
		end
	end

	// coefficients
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {target_x[IN_W-1], target_x} - {origin_x[IN_W-1], origin_x};
			dy_s1 <= {target_y[IN_W-1], target_y} - {origin_y[IN_W-1], origin_y};
			vx_s1 <= target_vel_x;
			vy_s1 <= target_vel_y;
			sp_s1 <= shot_speed;

			pvx_s2 <= vx_s1 * vx_s1;
			pvy_s2 <= vy_s1 * vy_s1;
			pss_s2 <= sp_s1 * sp_s1;
			pdx_s2 <= dx_s1 * dx_s1;
			pdy_s2 <= dy_s1 * dy_s1;
			phx_s2 <= dx_s1 * vx_s1;
			phy_s2 <= dy_s1 * vy_s1;
			slow_s2 <= (sp_s1 <= SPEED_MIN);
			geo_s2 <= '{dx: dx_s1, dy: dy_s1, vx: vx_s1, vy: vy_s1};

			a_s3 <= $signed({2'b00, pvx_s2}) + $signed({2'b00, pvy_s2})
				- $signed({4'b0000, pss_s2});
			h_s3 <= phx_s2 + phy_s2;
			c_s3 <= pdx_s2 + pdy_s2;
			slow_s3 <= slow_s2;
			geo_s3 <= geo_s2;

			sol_s4.geo <= geo_s3;
			sol_s4.slow <= slow_s3;
			sol_s4.lin <= (a_s3 >= -LIN_A_MAX) && (a_s3 <= LIN_A_MAX);
			sol_s4.linok <= (h_s3 <= -LIN_H_MIN) && (c_s3 != '0);
			sol_s4.apos <= !a_s3[49] && (a_s3 != '0);
			sol_s4.g <= (!a_s3[49] && (a_s3 != '0)) ? -h_s3 : h_s3;
			sol_s4.am <= a_s3[49] ? 50'(-a_s3) : 50'(a_s3);
			sol_s4.hm <= h_s3[50] ? 50'(-h_s3) : 50'(h_s3);
			sol_s4.c <= c_s3;
		end
	end

	// discriminant h^2 - a c from 25 bit partial products
	always_ff @(posedge clk) begin
		if (en) begin
			hh00_s5 <= sol_s4.hm[24:0] * sol_s4.hm[24:0];
			hh01_s5 <= sol_s4.hm[24:0] * sol_s4.hm[49:25];
			hh11_s5 <= sol_s4.hm[49:25] * sol_s4.hm[49:25];
			ac00_s5 <= sol_s4.am[24:0] * sol_s4.c[24:0];
			ac01_s5 <= sol_s4.am[24:0] * sol_s4.c[49:25];
			ac10_s5 <= sol_s4.am[49:25] * sol_s4.c[24:0];
			ac11_s5 <= sol_s4.am[49:25] * sol_s4.c[49:25];
			sol_s5 <= sol_s4;

			hh_s6 <= (100'(hh11_s5) << 50) + (100'(hh01_s5) << 26) + 100'(hh00_s5);
			ac_s6 <= (100'(ac11_s5) << 50) + ((100'(ac01_s5) + 100'(ac10_s5)) << 25)
				+ 100'(ac00_s5);
			sol_s6 <= sol_s5;

			q_s7 <= sol_s6.apos ? 98'(hh_s6 - ac_s6) : 98'(hh_s6 + ac_s6);
			sq1_s7.sol <= sol_s6;
			sq1_s7.disc_ok <= !sol_s6.apos || (ac_s6 <= hh_s6);
		end
	end

	pia_isqrt #(
		.QW(98),
		.SW($bits(sq1_sb_t))
	) u_sqrt_disc (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s7),
		.rad(q_s7),
		.in_sb(sq1_s7),
		.out_valid(v_r1),
		.root(r1),
		.out_sb(sq1o)
	);

	// earliest positive root or the linear case
	always_comb begin
		gm_c = {sq1o.sol.g[50], sq1o.sol.g} - {3'b000, r1};
		gp_c = {sq1o.sol.g[50], sq1o.sol.g} + {3'b000, r1};
		found_c = 1'b0;
		num_c = '0;
		den_c = 51'd1;
		if (!sq1o.sol.slow) begin
			if (sq1o.sol.lin) begin
				if (sq1o.sol.linok) begin
					found_c = 1'b1;
					num_c = 51'(sq1o.sol.c);
					den_c = {sq1o.sol.hm, 1'b0};
				end
			end else if (sq1o.disc_ok) begin
				den_c = 51'(sq1o.sol.am);
				if (gm_c > 0) begin
					found_c = 1'b1;
					num_c = 51'(gm_c);
				end else if (gp_c > 0) begin
					found_c = 1'b1;
					num_c = 51'(gp_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s8 <= num_c;
			den_s8 <= den_c;
			found_s8 <= found_c;
			geo_s8 <= sq1o.sol.geo;

			nn_s9 <= {num_s8, 16'b0};
			den_s9 <= den_s8;
			dv1_s9.found <= found_s8;
			dv1_s9.sat <= ({8'b0, num_s8} >= {den_s8, 8'b0});
			dv1_s9.geo <= geo_s8;
		end
	end

	pia_div #(
		.NW(67),
		.DW(51),
		.QW(TIME_W),
		.SW($bits(dv1_sb_t))
	) u_div_time (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s9),
		.num(nn_s9),
		.den(den_s9),
		.in_sb(dv1_s9),
		.out_valid(v_d1),
		.quo(q1),
		.out_sb(dv1o)
	);

	// group flags and in-group leading one
	always_comb begin
		mo_c = mx_s13 | my_s13;
		for (int gi = 0; gi < NGRP; gi++) begin
			gnz_c[gi] = |mo_c[gi*GRP +: GRP];
			gpos_c[gi] = '0;
			for (int b = 0; b < GRP; b++) begin
				if (mo_c[gi*GRP + b]) gpos_c[gi] = 3'(b);
			end
		end
	end

	always_comb begin
		p_c = '0;
		for (int gi = 0; gi < NGRP; gi++) begin
			if (gnz_s14[gi]) p_c = 6'(gi * GRP) + 6'(gpos_s14[gi]);
		end
	end

	always_comb begin
		if (p_s15 >= 6'(NORM_MSB)) begin
			sh_c = p_s15 - 6'(NORM_MSB);
			nx_c = 30'(mx_s15 >> sh_c);
			ny_c = 30'(my_s15 >> sh_c);
		end else begin
			sh_c = 6'(NORM_MSB) - p_s15;
			nx_c = 30'(mx_s15 << sh_c);
			ny_c = 30'(my_s15 << sh_c);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tq_s10 <= !dv1o.found ? '0 : (dv1o.sat ? TIME_SAT : q1);
			found_s10 <= dv1o.found;
			geo_s10 <= dv1o.geo;

			pvx_s11 <= geo_s10.vx * $signed({1'b0, tq_s10});
			pvy_s11 <= geo_s10.vy * $signed({1'b0, tq_s10});
			dx_s11 <= geo_s10.dx;
			dy_s11 <= geo_s10.dy;
			tq_s11 <= tq_s10;
			found_s11 <= found_s10;

			x_s12 <= $signed({{9{dx_s11[24]}}, dx_s11, 16'b0}) + $signed({pvx_s11[48], pvx_s11});
			y_s12 <= $signed({{9{dy_s11[24]}}, dy_s11, 16'b0}) + $signed({pvy_s11[48], pvy_s11});
			tq_s12 <= tq_s11;
			found_s12 <= found_s11;

			mx_s13 <= x_s12[49] ? 49'(-x_s12) : 49'(x_s12);
			my_s13 <= y_s12[49] ? 49'(-y_s12) : 49'(y_s12);
			sx_s13 <= x_s12[49];
			sy_s13 <= y_s12[49];
			tq_s13 <= tq_s12;
			found_s13 <= found_s12;

			gnz_s14 <= gnz_c;
			gpos_s14 <= gpos_c;
			mx_s14 <= mx_s13;
			my_s14 <= my_s13;
			sx_s14 <= sx_s13;
			sy_s14 <= sy_s13;
			tq_s14 <= tq_s13;
			found_s14 <= found_s13;

			p_s15 <= p_c;
			zero_s15 <= ~|gnz_s14;
			mx_s15 <= mx_s14;
			my_s15 <= my_s14;
			sx_s15 <= sx_s14;
			sy_s15 <= sy_s14;
			tq_s15 <= tq_s14;
			found_s15 <= found_s14;

			nx_s16 <= nx_c;
			ny_s16 <= ny_c;
			zero_s16 <= zero_s15;
			sx_s16 <= sx_s15;
			sy_s16 <= sy_s15;
			tq_s16 <= tq_s15;
			found_s16 <= found_s15;

			sqx_s17 <= nx_s16 * nx_s16;
			sqy_s17 <= ny_s16 * ny_s16;
			sq2_s17 <= '{nx: nx_s16, ny: ny_s16, sx: sx_s16, sy: sy_s16, zero: zero_s16,
				tq: tq_s16, found: found_s16};

			ss_s18 <= 62'(sqx_s17) + 62'(sqy_s17);
			sq2_s18 <= sq2_s17;
		end
	end

	pia_isqrt #(
		.QW(62),
		.SW($bits(sq2_sb_t))
	) u_sqrt_len (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s18),
		.rad(ss_s18),
		.in_sb(sq2_s18),
		.out_valid(v_r2),
		.root(r2),
		.out_sb(sq2o)
	);

	// rounded quotient setup: (n * 2^14 + len/2) / len
	always_ff @(posedge clk) begin
		if (en) begin
			ndx_s19 <= (45'(sq2o.nx) << Q14_SHIFT) + 45'(r2 >> 1);
			ndy_s19 <= (45'(sq2o.ny) << Q14_SHIFT) + 45'(r2 >> 1);
			len_s19 <= r2;
			dv2_s19 <= '{sx: sq2o.sx, zero: sq2o.zero, tq: sq2o.tq, found: sq2o.found};
			sy_s19 <= sq2o.sy;
		end
	end

	pia_div #(
		.NW(45),
		.DW(31),
		.QW(15),
		.SW($bits(dv2_sb_t))
	) u_div_aim_x (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s19),
		.num(ndx_s19),
		.den(len_s19),
		.in_sb(dv2_s19),
		.out_valid(dax_v),
		.quo(qx),
		.out_sb(dv2o)
	);

	pia_div #(
		.NW(45),
		.DW(31),
		.QW(15),
		.SW(1)
	) u_div_aim_y (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s19),
		.num(ndy_s19),
		.den(len_s19),
		.in_sb(sy_s19),
		.out_valid(day_v),
		.quo(qy),
		.out_sb(syo)
	);

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			aim_x <= dv2o.zero ? '0 : (dv2o.sx ? AIM_W'(0) - {1'b0, qx} : {1'b0, qx});
			aim_y <= dv2o.zero ? '0 : (syo ? AIM_W'(0) - {1'b0, qy} : {1'b0, qy});
			hit_time <= dv2o.tq;
			lead_used <= dv2o.found;
		end
	end

	`PIA_ASSERT_IMPL(a_lane_sync, dax_v | day_v, dax_v & day_v, "aim divider lanes out of step")
	`PIA_ASSERT_IMPL(a_no_lead_time, out_valid & ~lead_used, hit_time == '0, "time without lead")
	`PIA_ASSERT_IMPL(a_aim_range, out_valid, (aim_x <= 16'sd16384) && (aim_x >= -16'sd16384), "aim_x out of unit range")
	`PIA_ASSERT_NEXT(a_zero_vec, en & dax_v & dv2o.zero, (aim_x == '0) && (aim_y == '0), "zero vector not zero")
endmodule

>>> tb/tb.sv
// self-checking testbench for the projectile intercept aim pipeline
module tb;
	import pia_pkg::*;

	typedef struct {
		logic signed [IN_W-1:0] ox, oy, tx, ty, vx, vy;
		logic [SPD_W-1:0] spd;
		bit known;
		logic signed [AIM_W-1:0] ax, ay;
		logic [TIME_W-1:0] t;
		logic lead;
	} shot_row_t;

	typedef struct {
		logic signed [AIM_W-1:0] ax, ay;
		logic [TIME_W-1:0] t;
		logic lead;
	} aim_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [IN_W-1:0] origin_x = 0, origin_y = 0, target_x = 0, target_y = 0;
	logic signed [IN_W-1:0] target_vel_x = 0, target_vel_y = 0;
	logic [SPD_W-1:0] shot_speed = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [AIM_W-1:0] aim_x, aim_y;
	logic [TIME_W-1:0] hit_time;
	logic lead_used;

	aim_res_t aim_pending[$];
	shot_row_t shot_table[$];
	int errors = 0;
	int idle_max = 5;
	bit long_hold = 0;

	projectile_intercept_aim dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] root_floor(logic [127:0] q);
		logic [63:0] r;
		logic [127:0] cand;
		r = 0;
		for (int b = 48; b >= 0; b--) begin
			cand = {64'd0, r | (64'd1 << b)};
			if (cand * cand <= q)
				r = cand[63:0];
		end
		return r;
	endfunction

	function automatic void unit_dir(longint x, longint y, output logic signed [AIM_W-1:0] ux,
			output logic signed [AIM_W-1:0] uy);
		logic [63:0] mx, my, m, len, rx, ry;
		mx = x < 0 ? -x : x;
		my = y < 0 ? -y : y;
		m = mx > my ? mx : my;
		if (m == 0) begin
			ux = 0;
			uy = 0;
			return;
		end
		while (m >= (64'd1 << 30)) begin
			mx >>= 1; my >>= 1; m >>= 1;
		end
		while (m < (64'd1 << 29)) begin
			mx <<= 1; my <<= 1; m <<= 1;
		end
		len = root_floor({64'd0, mx * mx + my * my});
		rx = (mx * 16384 + len / 2) / len;
		ry = (my * 16384 + len / 2) / len;
		ux = x < 0 ? -rx[15:0] : rx[15:0];
		uy = y < 0 ? -ry[15:0] : ry[15:0];
	endfunction

	function automatic aim_res_t intercept_aim(shot_row_t w);
		aim_res_t res;
		longint dx, dy, vx, vy, s, a, h, c, g, r, tq;
		logic [63:0] num, den, big_a, mh, whole, rem;
		logic [127:0] hh, ac, q;
		bit found, real_ok;
		dx = longint'(w.tx) - longint'(w.ox);
		dy = longint'(w.ty) - longint'(w.oy);
		vx = w.vx;
		vy = w.vy;
		s = longint'({41'd0, w.spd});
		found = 0;
		num = 0;
		den = 1;
		tq = 0;
		if (s > 256) begin
			a = vx * vx + vy * vy - s * s;
			h = dx * vx + dy * vy;
			c = dx * dx + dy * dy;
			if (a >= -LIN_A_MAX && a <= LIN_A_MAX) begin
				if (h <= -LIN_H_MIN && c > 0) begin
					num = c;
					den = 2 * (-h);
					found = 1;
				end
			end else begin
				big_a = a < 0 ? -a : a;
				g = a > 0 ? -h : h;
				mh = h < 0 ? -h : h;
				hh = {64'd0, mh} * {64'd0, mh};
				ac = {64'd0, big_a} * {64'd0, 64'(c)};
				real_ok = 1;
				q = hh;
				if (a > 0) begin
					if (ac <= hh)
						q = hh - ac;
					else
						real_ok = 0;
				end else
					q = hh + ac;
				if (real_ok) begin
					r = root_floor(q);
					if (g - r > 0) begin
						num = g - r; den = big_a; found = 1;
					end else if (g + r > 0) begin
						num = g + r; den = big_a; found = 1;
					end
				end
			end
		end
		if (found) begin
			whole = num / den;
			if (whole >= 256)
				tq = TIME_SAT;
			else begin
				rem = num % den;
				rem = rem << 16;
				tq = whole * 65536 + rem / den;
			end
			unit_dir(dx * 65536 + vx * tq, dy * 65536 + vy * tq, res.ax, res.ay);
		end else
			unit_dir(dx, dy, res.ax, res.ay);
		res.t = tq[TIME_W-1:0];
		res.lead = found;
		return res;
	endfunction

	function automatic void add_row(int ox, int oy, int tx, int ty, int vx, int vy, int spd,
			bit known = 0, int ax = 0, int ay = 0, int t = 0, int lead = 0);
		shot_row_t w;
		w.ox = ox; w.oy = oy; w.tx = tx; w.ty = ty; w.vx = vx; w.vy = vy; w.spd = spd;
		w.known = known; w.ax = ax; w.ay = ay; w.t = t; w.lead = lead;
		shot_table.push_back(w);
	endfunction

	function automatic shot_row_t random_shot();
		shot_row_t w;
		int kind;
		kind = $urandom_range(0, 99);
		w.known = 0;
		if (kind < 15) begin
			w.ox = $urandom; w.oy = $urandom; w.tx = $urandom; w.ty = $urandom;
			w.vx = $urandom; w.vy = $urandom; w.spd = $urandom;
		end else begin
			w.ox = $signed($urandom_range(0, 262143)) - 131072;
			w.oy = $signed($urandom_range(0, 262143)) - 131072;
			w.tx = $signed($urandom_range(0, 262143)) - 131072;
			w.ty = $signed($urandom_range(0, 262143)) - 131072;
			w.vx = $signed($urandom_range(0, 32767)) - 16384;
			w.vy = $signed($urandom_range(0, 32767)) - 16384;
			w.spd = $urandom_range(257, 65535);
			if (kind < 28) begin
				// shot speed equal to target speed
				w.spd = $urandom_range(257, 32767);
				w.vx = $urandom_range(0, 1) ? -$signed({1'b0, w.spd}) : $signed({1'b0, w.spd});
				w.vy = 0;
			end else if (kind < 38)
				w.spd = $urandom_range(0, 256);
		end
		return w;
	endfunction

	initial begin
		shot_row_t w;
		int n_items, gap;
		add_row(0, 0, 256, 0, 0, 0, 100, 1, 16384, 0, 0, 0);
		add_row(5, 7, 5, 7, 1000, -1000, 0, 1, 0, 0, 0, 0);
		add_row(0, 256, 0, 0, 0, 0, 256, 1, 0, -16384, 0, 0);
		add_row(0, 0, 1, 0, 0, 0, 8388607, 1, 16384, 0, 0, 1);
		add_row(-8388608, 0, 8388607, 0, 0, 0, 257, 1, 16384, 0, 24'hFFFFFF, 1);
		add_row(0, 0, 0, 10000, 1000, 0, 500, 1, 0, 16384, 0, 0);
		add_row(0, 0, 10000, 0, 1000, 0, 500);
		add_row(0, 0, -10000, 0, 300, 0, 300);
		add_row(0, 0, -10000, 0, 300, 0, 310);
		add_row(0, 0, 20000, 5000, -2000, 700, 3000);
		add_row(8388607, 8388607, -8388608, -8388608, 8388607, 8388607, 8388607);
		add_row(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608, 8388607);
		add_row(8388607, -8388608, -8388608, 8388607, -8388608, 8388607, 257);
		add_row(100, 200, 300, 400, 5, 5, 1024);
		n_items = shot_table.size() + 840;
		repeat (5) @(posedge clk);
		arst_n = 1;
		@(posedge clk);
		for (int i = 0; i < n_items; i++) begin
			w = i < shot_table.size() ? shot_table[i] : random_shot();
			idle_max = (i % 150) < 40 ? 0 : 5;
			if (i == 200)
				long_hold = 1;
			if (i == 500) begin
				// drop valid while draining
				in_valid <= 0;
				while (aim_pending.size() != 0) @(posedge clk);
			end
			gap = $urandom_range(0, idle_max);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			origin_x <= w.ox; origin_y <= w.oy; target_x <= w.tx; target_y <= w.ty;
			target_vel_x <= w.vx; target_vel_y <= w.vy; shot_speed <= w.spd;
			do @(posedge clk); while (!in_ready);
			if (w.known)
				aim_pending.push_back('{w.ax, w.ay, w.t, w.lead});
			else
				aim_pending.push_back(intercept_aim(w));
		end
		in_valid <= 0;
		while (aim_pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// output side: random stalls plus one long hold-off
	initial begin
		aim_res_t e;
		int stall;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				stall = 400;
				long_hold = 0;
			end else
				stall = $urandom_range(0, idle_max);
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			if (aim_pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = aim_pending.pop_front();
				if (aim_x !== e.ax) begin
					$error("aim_x expected %0d got %0d", e.ax, aim_x); errors++;
				end
				if (aim_y !== e.ay) begin
					$error("aim_y expected %0d got %0d", e.ay, aim_y); errors++;
				end
				if (hit_time !== e.t) begin
					$error("hit_time expected %0h got %0h", e.t, hit_time); errors++;
				end
				if (lead_used !== e.lead) begin
					$error("lead_used expected %0b got %0b", e.lead, lead_used); errors++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end
endmodule
